// ===== sv/psd_pkg.sv =====
// shared constants, codes and types of the point to segment distance pipeline
`timescale 1ns / 1ps
package psd_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int DIST_BITS  = 26;

  // coordinate difference, product, cross product and magnitude widths
  localparam int DW  = COORD_BITS + 1;
  localparam int PW  = 2 * DW;
  localparam int CW  = PW + 1;
  localparam int MW  = CW - 1;
  localparam int LOW = MW / 2;
  localparam int HIW = MW - LOW;
  // squared numerator, divisor, dividend, quotient and root widths
  localparam int SW  = 2 * MW;
  localparam int LW  = PW;
  localparam int PBW = SW + 2 * FRAC_BITS + 2;
  localparam int QB  = 2 * COORD_BITS + 2 * FRAC_BITS + 3;
  localparam int RB  = (QB + 1) / 2;
  localparam int QE  = 2 * RB;

  localparam int IN_W  = ((6 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_W = ((DIST_BITS + 7) / 8) * 8;

  localparam logic [DIST_BITS-1:0] DIST_MAX = {1'b0, {(DIST_BITS - 1){1'b1}}};

  localparam logic [1:0] KIND_FOOT = 2'd0;
  localparam logic [1:0] KIND_B    = 2'd1;
  localparam logic [1:0] KIND_A    = 2'd2;

  typedef struct packed {
    logic       valid;
    logic       neg;
    logic [1:0] kind;
    logic       degen;
  } psd_side_t;

endpackage

// ===== sv/psd_front.sv =====
// geometry front end: differences, products, tests and the squared numerator
`timescale 1ns / 1ps
module psd_front import psd_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic signed [COORD_BITS-1:0] line_a_x,
  input  logic signed [COORD_BITS-1:0] line_a_y,
  input  logic signed [COORD_BITS-1:0] line_b_x,
  input  logic signed [COORD_BITS-1:0] line_b_y,
  input  logic signed [COORD_BITS-1:0] query_x,
  input  logic signed [COORD_BITS-1:0] query_y,
  input  logic                         seg_flag,
  output logic [SW-1:0]                num,
  output logic [LW-1:0]                den,
  output psd_side_t                    side
);

  // stage 1: differences
  logic signed [DW-1:0] ux, uy, ex, ey, fx, fy;
  logic                 v1, seg1;
  // stage 2: products
  logic signed [PW-1:0] pue, pve, puf, pvf, pc1, pc2, puu, pvv, pee, pff, pgg, phh;
  logic                 v2, seg2, deg2;
  // stage 3: sums and tests
  logic signed [CW-1:0] dotb, dota, cr, crn;
  logic [1:0]           kind3_next;
  logic [MW-1:0]        m3;
  logic [LW-1:0]        l3, s3;
  psd_side_t            sd3;
  // stage 4: partial products of the cross magnitude
  logic [2*HIW-1:0]     pp_hh;
  logic [HIW+LOW-1:0]   pp_hl;
  logic [2*LOW-1:0]     pp_ll;
  logic [LW-1:0]        l4, s4;
  psd_side_t            sd4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      seg1 <= seg_flag;
      ux   <= DW'(line_b_x) - DW'(line_a_x);
      uy   <= DW'(line_b_y) - DW'(line_a_y);
      ex   <= DW'(query_x) - DW'(line_b_x);
      ey   <= DW'(query_y) - DW'(line_b_y);
      fx   <= DW'(query_x) - DW'(line_a_x);
      fy   <= DW'(query_y) - DW'(line_a_y);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      seg2 <= seg1;
      deg2 <= (ux == '0) && (uy == '0);
      pue  <= ux * ex;
      pve  <= uy * ey;
      puf  <= ux * fx;
      pvf  <= uy * fy;
      pc1  <= ux * fy;
      pc2  <= uy * fx;
      puu  <= ux * ux;
      pvv  <= uy * uy;
      pee  <= ex * ex;
      pff  <= ey * ey;
      pgg  <= fx * fx;
      phh  <= fy * fy;
    end
  end

  assign dotb = CW'(pue) + CW'(pve);
  assign dota = CW'(puf) + CW'(pvf);
  assign cr   = CW'(pc1) - CW'(pc2);
  assign crn  = -cr;

  always_comb begin
    kind3_next = KIND_FOOT;
    if (!deg2 && seg2) begin
      if (!dotb[CW-1] && (dotb != '0)) begin
        kind3_next = KIND_B;
      end else if (dota[CW-1]) begin
        kind3_next = KIND_A;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sd3 <= '0;
    end else if (en) begin
      sd3.valid <= v2;
      sd3.degen <= deg2;
      sd3.kind  <= kind3_next;
      sd3.neg   <= !deg2 && (kind3_next == KIND_FOOT) && cr[CW-1];
    end
    if (en) begin
      m3 <= cr[CW-1] ? crn[MW-1:0] : cr[MW-1:0];
      l3 <= LW'(puu) + LW'(pvv);
      s3 <= (kind3_next == KIND_B) ? LW'(pee) + LW'(pff) : LW'(pgg) + LW'(phh);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sd4 <= '0;
    end else if (en) begin
      sd4 <= sd3;
    end
    if (en) begin
      pp_hh <= m3[MW-1:LOW] * m3[MW-1:LOW];
      pp_hl <= m3[MW-1:LOW] * m3[LOW-1:0];
      pp_ll <= m3[LOW-1:0] * m3[LOW-1:0];
      l4    <= l3;
      s4    <= s3;
    end
  end

  // stage 5: pick the numerator and divisor of the squared distance
  always_ff @(posedge clk) begin
    if (rst) begin
      side <= '0;
    end else if (en) begin
      side <= sd4;
    end
    if (en) begin
      if (sd4.degen) begin
        num <= '0;
        den <= LW'(1);
      end else if (sd4.kind != KIND_FOOT) begin
        num <= SW'(s4);
        den <= LW'(1);
      end else begin
        num <= (SW'(pp_hh) << (2 * LOW)) + (SW'(pp_hl) << (LOW + 1)) + SW'(pp_ll);
        den <= l4;
      end
    end
  end

endmodule

// ===== sv/psd_div.sv =====
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module psd_div import psd_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic [SW-1:0]   num,
  input  logic [LW-1:0]   den,
  input  psd_side_t       in_side,
  output logic [QB-1:0]   quot,
  output psd_side_t       out_side
);

  logic [PBW-1:0] dividend;
  logic [LW-1:0]  rem [QB];
  logic [QB-1:0]  dq  [QB];
  logic [LW-1:0]  dl  [QB];
  psd_side_t      sd  [QB];

  assign dividend = {num, {(2 * FRAC_BITS + 2){1'b0}}};

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [LW-1:0] r_in, l_in;
    logic [QB-1:0] q_in;
    psd_side_t     s_in;
    logic [LW:0]   t, diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign r_in = dividend[QB +: LW];
      assign q_in = dividend[QB-1:0];
      assign l_in = den;
      assign s_in = in_side;
    end else begin : g_next
      assign r_in = rem[k-1];
      assign q_in = dq[k-1];
      assign l_in = dl[k-1];
      assign s_in = sd[k-1];
    end

    assign t    = {r_in, q_in[QB-1]};
    assign ge   = t >= {1'b0, l_in};
    assign diff = t - {1'b0, l_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        sd[k] <= '0;
      end else if (en) begin
        sd[k] <= s_in;
      end
      if (en) begin
        rem[k] <= ge ? diff[LW-1:0] : t[LW-1:0];
        dq[k]  <= {q_in[QB-2:0], ge};
        dl[k]  <= l_in;
      end
    end
  end

  assign quot     = dq[QB-1];
  assign out_side = sd[QB-1];

endmodule

// ===== sv/psd_sqrt.sv =====
// pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps
module psd_sqrt import psd_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic [QB-1:0] quot,
  input  psd_side_t     in_side,
  output logic [RB-1:0] root,
  output psd_side_t     out_side
);

  logic [RB+1:0] rem [RB];
  logic [RB-1:0] rt  [RB];
  logic [QE-1:0] xs  [RB];
  psd_side_t     sd  [RB];

  for (genvar k = 0; k < RB; k++) begin : g_stage
    logic [RB+1:0] r_in;
    logic [RB-1:0] rt_in;
    logic [QE-1:0] x_in;
    psd_side_t     s_in;
    logic [RB+3:0] t, trial, diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign r_in  = '0;
      assign rt_in = '0;
      assign x_in  = QE'(quot);
      assign s_in  = in_side;
    end else begin : g_next
      assign r_in  = rem[k-1];
      assign rt_in = rt[k-1];
      assign x_in  = xs[k-1];
      assign s_in  = sd[k-1];
    end

    assign t     = {r_in, x_in[QE-1:QE-2]};
    assign trial = {2'b00, rt_in, 2'b01};
    assign ge    = t >= trial;
    assign diff  = t - trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        sd[k] <= '0;
      end else if (en) begin
        sd[k] <= s_in;
      end
      if (en) begin
        rem[k] <= ge ? diff[RB+1:0] : t[RB+1:0];
        rt[k]  <= {rt_in[RB-2:0], ge};
        xs[k]  <= {x_in[QE-3:0], 2'b00};
      end
    end
  end

  assign root     = rt[RB-1];
  assign out_side = sd[RB-1];

endmodule

// ===== sv/point_segment_distance.sv =====
// top level of the point to line or segment distance pipeline
`timescale 1ns / 1ps
// point to line / segment distance, one query per transaction
//
// slave channel s_*: endpoints a, b and query point c as signed integers,
// plus a segment flag in s_tuser. master channel m_*: signed distance with
// 8 fraction bits, rounded to nearest, the nearest feature kind and a
// degenerate flag (a equal to b gives distance zero).
//
// a new transaction is taken every cycle while the output is not stalled.
// the pipeline holds 5 geometry stages (differences, 17x17 products, sums
// and endpoint tests, split squaring of the cross product, numerator select),
// 51 stages of the restoring divider (one quotient bit each), 26 stages of
// the square root (one root bit each) and the output register.
//
// the whole pipeline advances on one enable: it moves while the output
// register is empty or being taken, so s_tready is low only while a result
// waits and m_tready is low; nothing is lost or repeated in a stall.
// reset clears every valid bit; no result comes out until new input.
module point_segment_distance import psd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // line_a_x, line_a_y, line_b_x, line_b_y, query_x, query_y
  input  logic [IN_W-1:0]  s_tdata,
  // segment flag
  input  logic             s_tuser,
  output logic             m_tvalid,
  input  logic             m_tready,
  // distance, zero padding
  output logic [OUT_W-1:0] m_tdata,
  // nearest_kind, degenerate
  output logic [2:0]       m_tuser
);

  logic                  en;
  logic [SW-1:0]         num;
  logic [LW-1:0]         den;
  psd_side_t             side_f, side_d, side_s;
  logic [QB-1:0]         quot;
  logic [RB-1:0]         root;
  logic [RB:0]           nsum;
  logic [RB-1:0]         nround;
  logic [DIST_BITS-1:0]  mag, dist_next;
  logic signed [DIST_BITS-1:0] distance;
  logic [1:0]            nearest_kind;
  logic                  degenerate;

  // pipeline moves whenever the output slot is free or being emptied
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  psd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (s_tvalid),
    .line_a_x   (s_tdata[0*COORD_BITS +: COORD_BITS]),
    .line_a_y   (s_tdata[1*COORD_BITS +: COORD_BITS]),
    .line_b_x   (s_tdata[2*COORD_BITS +: COORD_BITS]),
    .line_b_y   (s_tdata[3*COORD_BITS +: COORD_BITS]),
    .query_x    (s_tdata[4*COORD_BITS +: COORD_BITS]),
    .query_y    (s_tdata[5*COORD_BITS +: COORD_BITS]),
    .seg_flag   (s_tuser),
    .num        (num),
    .den        (den),
    .side       (side_f)
  );

  // squared distance scaled by 4 * 2^(2*frac), truncated
  psd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .num      (num),
    .den      (den),
    .in_side  (side_f),
    .quot     (quot),
    .out_side (side_d)
  );

  psd_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .quot     (quot),
    .in_side  (side_d),
    .root     (root),
    .out_side (side_s)
  );

  // root of 4*d^2 is 2*d; halving with a carry gives round half up
  assign nsum   = {1'b0, root} + (RB + 1)'(1);
  assign nround = nsum[RB:1];

  always_comb begin
    if ({{DIST_BITS{1'b0}}, nround} > (RB + DIST_BITS)'(DIST_MAX)) begin
      mag = DIST_MAX;
    end else begin
      mag = DIST_BITS'(nround);
    end
    dist_next = side_s.neg ? -mag : mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= side_s.valid;
    end
    if (en) begin
      distance     <= dist_next;
      nearest_kind <= side_s.kind;
      degenerate   <= side_s.degen;
    end
  end

  assign m_tdata = OUT_W'({{(OUT_W - DIST_BITS){1'b0}}, distance});
  assign m_tuser = {degenerate, nearest_kind};

  // a degenerate line always reports zero at the foot kind
  a_degen_zero : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && degenerate) |-> (distance == '0 && nearest_kind == KIND_FOOT))
    else $error("degenerate result with nonzero distance or kind");

  // endpoint distances are never negative
  a_endpoint_pos : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && nearest_kind != KIND_FOOT) |-> !distance[DIST_BITS-1])
    else $error("negative endpoint distance");

  // unused kind code never leaves the block
  a_kind_code : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (nearest_kind == KIND_FOOT || nearest_kind == KIND_B ||
                  nearest_kind == KIND_A))
    else $error("bad nearest kind code");

endmodule
